/* rtl/lkvc_pkg.sv */
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

   // access command carried with every request
   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } command_type;

   // capacity register
   localparam int unsigned CAP_BITS  = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // width of the value returned on the response channel
   localparam int unsigned READ_BITS = 32;

endpackage

/* rtl/lkvc_store.sv */
// Entry store: parallel key match, LRU rank tracking, fill and replacement.
`timescale 1ns / 1ps

module lkvc_store
   import lkvc_pkg::*;
#(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 16,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  command_type           command,
   input  logic [KEY_BITS-1:0]   key,
   input  logic [VALUE_BITS-1:0] value,
   input  logic [CAP_BITS-1:0]   capacity,
   output logic                  hit,
   output logic [VALUE_BITS-1:0] read_value
);

   localparam int unsigned AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam int unsigned CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

   logic [KEY_BITS-1:0]   keys_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] values_ff [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [AGE_W-1:0]      age_ff    [ENTRIES];
   logic [AGE_W-1:0]      age_in    [ENTRIES];
   logic [CNT_W-1:0]      occupancy_ff, occupancy_in;

   logic [ENTRIES-1:0]    match, oldest, free_sel, sel;
   logic [AGE_W-1:0]      hit_age, last_rank, rank;
   logic [CMP_W-1:0]      cap_eff, occ_ext;
   logic                  is_put, full, evict, fill, free_seen;

   // clamp capacity to 1 .. ENTRIES
   always_comb begin
      cap_eff = CMP_W'(capacity);
      if (capacity == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_eff > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end

   assign occ_ext   = CMP_W'(occupancy_ff);
   assign full      = occ_ext >= cap_eff;
   assign last_rank = AGE_W'(occupancy_ff - CNT_W'(1));
   assign is_put    = (command == CMD_PUT);

   // keys among valid entries are unique, so match is one-hot or empty
   always_comb begin
      hit_age    = '0;
      read_value = '0;
      free_seen  = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (keys_ff[i] == key);
         // ranks are distinct, the least recent holds occupancy-1
         oldest[i] = valid_ff[i] && (age_ff[i] == last_rank);
         free_sel[i] = !valid_ff[i] && !free_seen;
         free_seen   = free_seen || !valid_ff[i];
         if (match[i]) begin
            hit_age    = hit_age | age_ff[i];
            read_value = read_value | values_ff[i];
         end
      end
   end

   assign hit   = |match;
   assign evict = is_put && !hit && full;
   assign fill  = is_put && !hit && !full;
   assign sel   = hit ? match : (evict ? oldest : (fill ? free_sel : '0));
   assign rank  = hit ? hit_age : last_rank;

   always_comb begin
      valid_in     = valid_ff;
      occupancy_in = occupancy_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (hit || evict) begin
            // promote selected entry, age the younger ones
            if (sel[i]) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (age_ff[i] < rank)) begin
               age_in[i] = age_ff[i] + AGE_W'(1);
            end
         end else if (fill) begin
            if (sel[i]) begin
               valid_in[i] = 1'b1;
               age_in[i]   = '0;
            end else if (valid_ff[i]) begin
               age_in[i] = age_ff[i] + AGE_W'(1);
            end
         end
      end
      if (fill) begin
         occupancy_in = occupancy_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occupancy_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else if (enable) begin
         valid_ff     <= valid_in;
         occupancy_ff <= occupancy_in;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i] && (evict || fill)) begin
               keys_ff[i] <= key;
            end
            if (sel[i] && is_put) begin
               values_ff[i] <= value;
            end
         end
      end
   end

endmodule

/* rtl/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: handshakes, capacity register, result register.
//
// Usage: each request transfer on the req_ channel carries a command (get or put), a key
// and a value. Every request yields exactly one response transfer on the rsp_ channel:
// rsp_hit tells whether the key was present before the access, rsp_read_value holds the
// stored value on a get hit and zero otherwise.
// A transfer happens at a rising edge with valid high and stall low; the receiver drives
// stall. The capacity register is written over the csr_ channel (valid/ready, always
// ready) and should only be written while no request is in flight.
// Pipeline: a request taken at a rising edge sits in the input register; it is looked up and
// updates the store once the output register is empty or being drained, and its response then
// enters the output register and rsp_valid rises. Throughput is one request per cycle while
// rsp_stall is low, set by the parallel key compare and rank update over all entries.
// When rsp_stall is held, the output register holds its response, the input register
// holds its request and req_stall goes high while a request is held; nothing is dropped.
// Reset (synchronous, active high) empties the cache, sets the capacity to 16 and
// clears the valid flags of both pipeline registers. No clearing pass is needed.
`timescale 1ns / 1ps

module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 16,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic signed [READ_BITS-1:0]  rsp_read_value,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CAP_BITS-1:0]          csr_capacity_limit
);

   logic                  req_valid_ff;
   command_type           req_command_ff;
   logic [KEY_BITS-1:0]   req_key_ff;
   logic [VALUE_BITS-1:0] req_value_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [READ_BITS-1:0]  rsp_read_value_ff, rsp_read_value_in;
   logic [CAP_BITS-1:0]   capacity_ff;
   logic                  rsp_load, req_take, hit;
   logic [VALUE_BITS-1:0] read_value;
   logic [READ_BITS+VALUE_BITS-1:0] read_wide;

   assign csr_ready = 1'b1;
   // advance when the output register is empty or being drained
   assign rsp_load  = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !rsp_load;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_capacity_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (rsp_load) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_command_ff <= command_type'(req_command);
         req_key_ff     <= req_key;
         req_value_ff   <= req_value;
      end
   end

   lkvc_store #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .enable     (rsp_load),
      .command    (req_command_ff),
      .key        (req_key_ff),
      .value      (req_value_ff),
      .capacity   (capacity_ff),
      .hit        (hit),
      .read_value (read_value)
   );

   // zero-extend or truncate to the response width; puts return zero
   assign read_wide = {{READ_BITS{1'b0}}, read_value};
   assign rsp_read_value_in = (req_command_ff == CMD_GET) ? read_wide[READ_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff        <= hit;
         rsp_read_value_ff <= rsp_read_value_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule
